@@ hdl/bsc_pkg.sv @@
// Shared constants for the barometer sample compensation block.
package bsc_pkg;

  localparam int DIV_W = 32;

  localparam logic [2:0] REG_CAL_AC123    = 3'd0;
  localparam logic [2:0] REG_CAL_AC456    = 3'd1;
  localparam logic [2:0] REG_CAL_B12      = 3'd2;
  localparam logic [2:0] REG_CAL_MC_MD    = 3'd3;
  localparam logic [2:0] REG_OVERSAMPLING = 3'd4;

  localparam logic [31:0] B6_OFFSET   = 32'd4000;
  localparam logic [31:0] P_SQ_COEF   = 32'd3038;
  localparam logic [31:0] P_LIN_COEF  = 32'hFFFF_E343; // -7357
  localparam logic [31:0] P_OFFSET    = 32'd3791;
  localparam logic [31:0] B7_SCALE    = 32'd50000;
  localparam logic [31:0] B4_OFFSET   = 32'd32768;

endpackage

@@ hdl/bsc_div.sv @@
// Pipelined unsigned restoring divider, one quotient bit per stage.
module bsc_div
  import bsc_pkg::*;
#(
  parameter int W    = DIV_W,
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_v,
  input  logic [W-1:0]    num,
  input  logic [W-1:0]    den,
  input  logic [SB_W-1:0] sb_in,
  output logic            out_v,
  output logic [W-1:0]    quo,
  output logic [SB_W-1:0] sb_out
);

  // acc holds {partial remainder, remaining dividend / quotient bits}
  logic [2*W-1:0]  acc [0:W];
  logic [W-1:0]    dsr [0:W];
  logic [SB_W-1:0] sb  [0:W];
  logic            v   [0:W];

  assign acc[0] = {{W{1'b0}}, num};
  assign dsr[0] = den;
  assign sb[0]  = sb_in;
  assign v[0]   = in_v;

  for (genvar k = 0; k < W; k++) begin : g_step
    logic [W:0]     sh;
    logic [W:0]     diff;
    logic [2*W-1:0] nxt;

    always_comb begin
      sh   = {acc[k][2*W-1:W], acc[k][W-1]};
      diff = sh - {1'b0, dsr[k]};
      if (diff[W]) begin
        nxt = {sh[W-1:0], acc[k][W-2:0], 1'b0};
      end else begin
        nxt = {diff[W-1:0], acc[k][W-2:0], 1'b1};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc[k+1] <= nxt;
        dsr[k+1] <= dsr[k];
        sb[k+1]  <= sb[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end
  end

  assign out_v  = v[W];
  assign quo    = acc[W][W-1:0];
  assign sb_out = sb[W];

endmodule

@@ hdl/barometer_sample_compensation.sv @@
// Top level: integer barometer compensation pipeline with two pipelined dividers.
//
// Input channel: in_valid / in_stall carry one word of temp_adc and
// raw_pressure_bytes. Output channel: out_valid / out_stall carry one word of
// temperature_decidegrees (0.1 C), pressure_pascal and divide_error.
// Calibration and oversampling are written via cfg_we/cfg_index/cfg_data by the
// user only while the pipeline is empty (unenforced); unknown indexes ignored.
//
// Pipeline: 2 front stages, a 32-stage unsigned divider on magnitudes for the
// signed temperature term, 10 arithmetic stages, a 32-stage unsigned divider
// for pressure, 4 back stages. Throughput: one word per cycle unless the output
// is stalled; the dividers are one quotient bit per stage, each stage registered.
//
// Stall: the whole pipeline moves as one. When out_valid is high and
// out_stall is high every stage holds, and in_stall is raised in the same
// cycle; nothing is dropped or repeated. Empty stages carry a low valid bit.
//
// Reset: clears all valid bits, calibration registers to 0, oversampling to 3.
// A zero divisor sets divide_error and forces both result fields to zero.
module barometer_sample_compensation
  import bsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        temp_adc,
  input  logic [23:0]        raw_pressure_bytes,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] temperature_decidegrees,
  output logic signed [31:0] pressure_pascal,
  output logic               divide_error
);

  localparam int SB1_W = 32 + 24 + 1 + 1;
  localparam int SB2_W = 16 + 1 + 1;

  // ---------------- configuration registers ----------------
  logic [47:0] cal_ac123, cal_ac456;
  logic [31:0] cal_b12, cal_mc_md;
  logic [1:0]  oversampling;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_ac123    <= '0;
      cal_ac456    <= '0;
      cal_b12      <= '0;
      cal_mc_md    <= '0;
      oversampling <= 2'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAL_AC123:    cal_ac123    <= cfg_data;
        REG_CAL_AC456:    cal_ac456    <= cfg_data;
        REG_CAL_B12:      cal_b12      <= cfg_data[31:0];
        REG_CAL_MC_MD:    cal_mc_md    <= cfg_data[31:0];
        REG_OVERSAMPLING: oversampling <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = {{16{cal_ac123[47]}}, cal_ac123[47:32]};
  assign ac2 = {{16{cal_ac123[31]}}, cal_ac123[31:16]};
  assign ac3 = {{16{cal_ac123[15]}}, cal_ac123[15:0]};
  assign ac4 = {16'd0, cal_ac456[47:32]};
  assign ac5 = {16'd0, cal_ac456[31:16]};
  assign ac6 = {16'd0, cal_ac456[15:0]};
  assign b1  = {{16{cal_b12[31]}}, cal_b12[31:16]};
  assign b2  = {{16{cal_b12[15]}}, cal_b12[15:0]};
  assign mc  = {{16{cal_mc_md[31]}}, cal_mc_md[31:16]};
  assign md  = {{16{cal_mc_md[15]}}, cal_mc_md[15:0]};

  // whole pipeline advances unless the output word is held
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // ---------------- stage 1: temperature product ----------------
  logic        v1;
  logic [31:0] s1_prod;
  logic [23:0] s1_up;

  // ---------------- stage 2: divider operands ----------------
  logic        v2;
  logic [31:0] s2_x1, s2_num, s2_den;
  logic [23:0] s2_up;
  logic        s2_err, s2_neg;

  logic [31:0] s2_x1_next, s2_den_raw, s2_mcs;
  always_comb begin
    s2_x1_next = $signed(s1_prod) >>> 15;
    s2_den_raw = s2_x1_next + md;
    s2_mcs     = mc << 11;
  end

  // divider 1 outputs
  logic             d1_v;
  logic [31:0]      d1_q;
  logic [SB1_W-1:0] d1_sb;
  logic [31:0]      d1_x1;
  logic [23:0]      d1_up;
  logic             d1_err, d1_neg;
  assign {d1_x1, d1_up, d1_err, d1_neg} = d1_sb;

  bsc_div #(.W(DIV_W), .SB_W(SB1_W)) u_div_t (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .in_v   (v2),
    .num    (s2_num),
    .den    (s2_den),
    .sb_in  ({s2_x1, s2_up, s2_err, s2_neg}),
    .out_v  (d1_v),
    .quo    (d1_q),
    .sb_out (d1_sb)
  );

  // ---------------- stages 4..13 ----------------
  logic        v4, v5, v6, v7, v8, v9, v10, v11, v12, v13;
  logic [31:0] s4_b5;
  logic [23:0] s4_up, s5_up, s6_up, s7_up, s8_up, s9_up, s10_up;
  logic        s4_err, s5_err, s6_err, s7_err, s8_err, s9_err, s10_err, s11_err, s12_err;
  logic [15:0] s5_temp, s6_temp, s7_temp, s8_temp, s9_temp, s10_temp, s11_temp, s12_temp;
  logic [31:0] s5_b6;
  logic [31:0] s6_sqr, s6_m2, s6_m3;
  logic [31:0] s7_sq, s7_x2a, s7_x1c;
  logic [31:0] s8_mb2, s8_mb1, s8_x2a, s8_x1c;
  logic [31:0] s9_x3a, s9_sum;
  logic [31:0] s10_b3, s10_t;
  logic [31:0] s11_pb4, s11_diff;
  logic [31:0] s12_b4, s12_b7;
  logic [31:0] s13_num, s13_den;
  logic        s13_err, s13_big;
  logic [15:0] s13_temp;

  logic [31:0] s4_x2, s5_r, s10_b3_pre, s12_b7_next;
  always_comb begin
    s4_x2       = d1_neg ? (32'd0 - d1_q) : d1_q;
    s5_r        = $signed(s4_b5 + 32'd8) >>> 4;
    s10_b3_pre  = ((ac1 * 32'd4) + s9_x3a) << oversampling;
    s12_b7_next = s11_diff * (B7_SCALE >> oversampling);
  end

  // divider 2 outputs
  logic             d2_v;
  logic [31:0]      d2_q;
  logic [SB2_W-1:0] d2_sb;
  logic [15:0]      d2_temp;
  logic             d2_err, d2_big;
  assign {d2_temp, d2_err, d2_big} = d2_sb;

  bsc_div #(.W(DIV_W), .SB_W(SB2_W)) u_div_p (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .in_v   (v13),
    .num    (s13_num),
    .den    (s13_den),
    .sb_in  ({s13_temp, s13_err, s13_big}),
    .out_v  (d2_v),
    .quo    (d2_q),
    .sb_out (d2_sb)
  );

  // ---------------- stages 15..18 ----------------
  logic        v15, v16, v17;
  logic [31:0] s15_p, s16_p, s17_p;
  logic [31:0] s16_sqa, s16_m;
  logic [31:0] s17_m3038, s17_x2;
  logic [15:0] s15_temp, s16_temp, s17_temp;
  logic        s15_err, s16_err, s17_err;

  logic [31:0] s16_a, s18_x1, s18_corr, s18_p;
  always_comb begin
    s16_a    = $signed(s15_p) >>> 8;
    s18_x1   = $signed(s17_m3038) >>> 16;
    s18_corr = $signed(s18_x1 + s17_x2 + P_OFFSET) >>> 4;
    s18_p    = s17_p + s18_corr;
  end

  // payload registers, all held while stalled
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_prod  <= ({16'd0, temp_adc} - ac6) * ac5;
      s1_up    <= raw_pressure_bytes >> (4'd8 - {2'b00, oversampling});

      s2_x1    <= s2_x1_next;
      s2_up    <= s1_up;
      s2_err   <= (s2_den_raw == 32'd0);
      s2_neg   <= s2_mcs[31] ^ s2_den_raw[31];
      s2_num   <= s2_mcs[31] ? (32'd0 - s2_mcs) : s2_mcs;
      s2_den   <= s2_den_raw[31] ? (32'd0 - s2_den_raw) : s2_den_raw;

      s4_b5    <= d1_x1 + s4_x2;
      s4_up    <= d1_up;
      s4_err   <= d1_err;

      s5_temp  <= s5_r[15:0];
      s5_b6    <= s4_b5 - B6_OFFSET;
      s5_up    <= s4_up;
      s5_err   <= s4_err;

      s6_sqr   <= s5_b6 * s5_b6;
      s6_m2    <= ac2 * s5_b6;
      s6_m3    <= ac3 * s5_b6;
      s6_temp  <= s5_temp;
      s6_up    <= s5_up;
      s6_err   <= s5_err;

      s7_sq    <= $signed(s6_sqr) >>> 12;
      s7_x2a   <= $signed(s6_m2) >>> 11;
      s7_x1c   <= $signed(s6_m3) >>> 13;
      s7_temp  <= s6_temp;
      s7_up    <= s6_up;
      s7_err   <= s6_err;

      s8_mb2   <= b2 * s7_sq;
      s8_mb1   <= b1 * s7_sq;
      s8_x2a   <= s7_x2a;
      s8_x1c   <= s7_x1c;
      s8_temp  <= s7_temp;
      s8_up    <= s7_up;
      s8_err   <= s7_err;

      // shifts wrapped so the sums do not turn them into logical shifts
      s9_x3a   <= $unsigned($signed(s8_mb2) >>> 11) + s8_x2a;
      s9_sum   <= $unsigned($signed(s8_mb1) >>> 16) + s8_x1c + 32'd2;
      s9_temp  <= s8_temp;
      s9_up    <= s8_up;
      s9_err   <= s8_err;

      s10_b3   <= $signed(s10_b3_pre + 32'd2) >>> 2;
      s10_t    <= $unsigned($signed(s9_sum) >>> 2) + B4_OFFSET;
      s10_temp <= s9_temp;
      s10_up   <= s9_up;
      s10_err  <= s9_err;

      s11_pb4  <= ac4 * s10_t;
      s11_diff <= {8'd0, s10_up} - s10_b3;
      s11_temp <= s10_temp;
      s11_err  <= s10_err;

      s12_b4   <= s11_pb4 >> 15;
      s12_b7   <= s12_b7_next;
      s12_temp <= s11_temp;
      s12_err  <= s11_err;

      s13_err  <= s12_err || (s12_b4 == 32'd0);
      s13_big  <= s12_b7[31];
      s13_num  <= s12_b7[31] ? s12_b7 : (s12_b7 << 1);
      s13_den  <= s12_b4;
      s13_temp <= s12_temp;

      s15_p    <= d2_big ? (d2_q << 1) : d2_q;
      s15_temp <= d2_temp;
      s15_err  <= d2_err;

      s16_sqa  <= s16_a * s16_a;
      s16_m    <= P_LIN_COEF * s15_p;
      s16_p    <= s15_p;
      s16_temp <= s15_temp;
      s16_err  <= s15_err;

      s17_m3038 <= s16_sqa * P_SQ_COEF;
      s17_x2    <= $signed(s16_m) >>> 16;
      s17_p     <= s16_p;
      s17_temp  <= s16_temp;
      s17_err   <= s16_err;

      temperature_decidegrees <= s17_err ? 16'sd0 : $signed(s17_temp);
      pressure_pascal         <= s17_err ? 32'sd0 : $signed(s18_p);
      divide_error            <= s17_err;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
      v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0; v10 <= 1'b0; v11 <= 1'b0;
      v12 <= 1'b0; v13 <= 1'b0; v15 <= 1'b0; v16 <= 1'b0; v17 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1  <= in_valid;
      v2  <= v1;
      v4  <= d1_v;
      v5  <= v4;
      v6  <= v5;
      v7  <= v6;
      v8  <= v7;
      v9  <= v8;
      v10 <= v9;
      v11 <= v10;
      v12 <= v11;
      v13 <= v12;
      v15 <= d2_v;
      v16 <= v15;
      v17 <= v16;
      out_valid <= v17;
    end
  end

  // ---------------- assertions ----------------
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_error |-> pressure_pascal == 32'sd0 &&
                                  temperature_decidegrees == 16'sd0)
    else $error("divide error with nonzero result");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_hold_pipe: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(v17) && $stable(v2))
    else $error("pipeline moved while output held");

endmodule
